/* rtl/ogs_pkg.sv */
// shared constants and types of the outlier-gated gaussian smoother
// no dependencies; every rtl module imports it

package ogs_pkg;

  // pixel and geometry widths
  localparam int PIX_W      = 16;
  localparam int MAX_LINE   = 4096;
  localparam int COL_W      = $clog2(MAX_LINE);
  localparam int LW_W       = 13;
  localparam int ROW_W      = 16;
  localparam int IN_ROW_W   = ROW_W + 1;
  localparam int MIN_DIM    = 5;
  localparam int EDGE       = 2;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER_LIMIT = 2'd0,
    REG_LOWER_LIMIT = 2'd1,
    REG_LINE_WIDTH  = 2'd2,
    REG_LINE_COUNT  = 2'd3
  } cfg_reg_e;

  // window and line store shape
  localparam int WIN        = 5;
  localparam int LINE_ROWS  = WIN - 1;

  // gaussian weights (kernel times 1000), grouped by symmetry
  localparam int NUM_GRP    = 6;
  localparam int GRP_CORNER = 0;  // weight 3, four corners
  localparam int GRP_EDGE13 = 1;  // weight 13, eight places
  localparam int GRP_EDGE22 = 2;  // weight 22, outer ring centers
  localparam int GRP_DIAG   = 3;  // weight 59, inner diagonals
  localparam int GRP_CROSS  = 4;  // weight 97, inner cross
  localparam int GRP_CENTER = 5;  // weight 159
  localparam logic [NUM_GRP-1:0][7:0] GRP_WEIGHT =
    {8'd159, 8'd97, 8'd59, 8'd22, 8'd13, 8'd3};

  localparam int GSUM_W     = PIX_W + 3;   // up to eight pixels per group
  localparam int ACC_W      = 26;          // 65535 * 987 < 2**26

  // divide by 1000: q = (acc * ceil(2**36 / 1000)) >> 36, exact for acc < 2**26
  localparam int RECIP_W     = 27;
  localparam int RECIP_SHIFT = 36;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 27'd68719477;
  localparam int PROD_W      = ACC_W + RECIP_W;

  // result queue
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [LINE_ROWS-1:0][PIX_W-1:0] line_word_t;
  typedef logic [WIN-1:0][WIN-1:0][PIX_W-1:0] window_t;  // [row][column]

  // item handed from the counter stage to the line store
  typedef struct packed {
    logic             valid;
    logic             emit;
    logic [PIX_W-1:0] pix;
    logic [COL_W-1:0] col;
    logic             interior;
    logic             last;
  } line_item_t;

  // control that travels alongside the shifted window
  typedef struct packed {
    logic valid;
    logic interior;
    logic last;
  } win_ctl_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             smoothed;
    logic             last;
  } out_item_t;

endpackage

/* rtl/ogs_line_window.sv */
// four-line store in one synchronous memory plus the 5x5 window registers
// depends on ogs_pkg

module ogs_line_window
  import ogs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  line_item_t item_i,
  output win_ctl_t   ctl_o,
  output window_t    win_o
);

  line_word_t line_mem [MAX_LINE];

  line_word_t rd_data_q;
  line_word_t fwd_data_q;
  logic       fwd_hit_q;
  line_item_t s1_q;
  window_t    win_q;
  win_ctl_t   ctl_q;

  line_word_t               line_rows;
  line_word_t               wr_data;
  logic [WIN-1:0][PIX_W-1:0] col_vec;

  // read column on acceptance
  always_ff @(posedge clk_i) begin
    if (item_i.valid) begin
      rd_data_q <= line_mem[item_i.col];
    end
  end

  // write back the column shifted up by one row
  always_ff @(posedge clk_i) begin
    if (s1_q.valid) begin
      line_mem[s1_q.col] <= wr_data;
    end
  end

  // same column written on the edge of this read: take the write data
  always_ff @(posedge clk_i) begin
    if (item_i.valid) begin
      fwd_data_q <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
      s1_q      <= '0;
    end else begin
      if (item_i.valid) begin
        fwd_hit_q <= s1_q.valid && (item_i.col == s1_q.col);
      end
      s1_q <= item_i;
    end
  end

  always_comb begin
    line_rows = fwd_hit_q ? fwd_data_q : rd_data_q;
    for (int k = 0; k < LINE_ROWS; k++) begin
      col_vec[k] = line_rows[k];
    end
    col_vec[WIN-1] = s1_q.pix;
    for (int k = 0; k < LINE_ROWS; k++) begin
      wr_data[k] = col_vec[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      ctl_q <= '0;
    end else begin
      if (s1_q.valid) begin
        for (int r = 0; r < WIN; r++) begin
          for (int c = 0; c < WIN - 1; c++) begin
            win_q[r][c] <= win_q[r][c+1];
          end
          win_q[r][WIN-1] <= col_vec[r];
        end
      end
      ctl_q.valid    <= s1_q.valid && s1_q.emit;
      ctl_q.interior <= s1_q.interior;
      ctl_q.last     <= s1_q.last;
    end
  end

  assign ctl_o = ctl_q;
  assign win_o = win_q;

endmodule

/* rtl/ogs_gauss.sv */
// outlier test and pipelined 5x5 gaussian with exact divide by 1000
// depends on ogs_pkg

module ogs_gauss
  import ogs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  win_ctl_t         ctl_i,
  input  window_t          win_i,
  input  logic [PIX_W-1:0] upper_i,
  input  logic [PIX_W-1:0] lower_i,
  output logic             res_valid_o,
  output out_item_t        res_o
);

  typedef struct packed {
    logic [PIX_W-1:0] centre;
    logic             smooth;
    logic             last;
  } side_t;

  logic [3:0] valid_q;

  side_t                           g1_side_q, g2_side_q, g3_side_q, g4_side_q;
  logic [NUM_GRP-1:0][GSUM_W-1:0]  gsum_d, gsum_q;
  logic [NUM_GRP-1:0][ACC_W-1:0]   prod_d, prod_q;
  logic [ACC_W-1:0]                acc_d, acc_q;
  logic [PROD_W-1:0]               quot_d, quot_q;
  side_t                           side_d;

  // group sums by weight
  always_comb begin
    gsum_d[GRP_CORNER] = GSUM_W'(win_i[0][0]) + GSUM_W'(win_i[0][4]) +
                         GSUM_W'(win_i[4][0]) + GSUM_W'(win_i[4][4]);
    gsum_d[GRP_EDGE13] = GSUM_W'(win_i[0][1]) + GSUM_W'(win_i[0][3]) +
                         GSUM_W'(win_i[1][0]) + GSUM_W'(win_i[1][4]) +
                         GSUM_W'(win_i[3][0]) + GSUM_W'(win_i[3][4]) +
                         GSUM_W'(win_i[4][1]) + GSUM_W'(win_i[4][3]);
    gsum_d[GRP_EDGE22] = GSUM_W'(win_i[0][2]) + GSUM_W'(win_i[2][0]) +
                         GSUM_W'(win_i[2][4]) + GSUM_W'(win_i[4][2]);
    gsum_d[GRP_DIAG]   = GSUM_W'(win_i[1][1]) + GSUM_W'(win_i[1][3]) +
                         GSUM_W'(win_i[3][1]) + GSUM_W'(win_i[3][3]);
    gsum_d[GRP_CROSS]  = GSUM_W'(win_i[1][2]) + GSUM_W'(win_i[2][1]) +
                         GSUM_W'(win_i[2][3]) + GSUM_W'(win_i[3][2]);
    gsum_d[GRP_CENTER] = GSUM_W'(win_i[2][2]);

    side_d.centre = win_i[2][2];
    side_d.smooth = ctl_i.interior &&
                    ((win_i[2][2] > upper_i) || (win_i[2][2] < lower_i));
    side_d.last   = ctl_i.last;
  end

  // constant weight products
  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      prod_d[g] = ACC_W'(gsum_q[g]) * ACC_W'(GRP_WEIGHT[g]);
    end
  end

  assign acc_d = prod_q[0] + prod_q[1] + prod_q[2] + prod_q[3] + prod_q[4] + prod_q[5];

  assign quot_d = PROD_W'(acc_q) * PROD_W'(RECIP_1000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[2:0], ctl_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    gsum_q    <= gsum_d;
    g1_side_q <= side_d;
    prod_q    <= prod_d;
    g2_side_q <= g1_side_q;
    acc_q     <= acc_d;
    g3_side_q <= g2_side_q;
    quot_q    <= quot_d;
    g4_side_q <= g3_side_q;
  end

  assign res_valid_o    = valid_q[3];
  assign res_o.pixel    = g4_side_q.smooth ? quot_q[RECIP_SHIFT +: PIX_W] : g4_side_q.centre;
  assign res_o.smoothed = g4_side_q.smooth;
  assign res_o.last     = g4_side_q.last;

endmodule

/* rtl/ogs_out_fifo.sv */
// result queue between the gaussian pipeline and the output channel
// depends on ogs_pkg

module ogs_out_fifo
  import ogs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_valid_i,
  input  out_item_t wr_item_i,
  output logic      rd_valid_o,
  input  logic      rd_stall_i,
  output out_item_t rd_item_o
);

  out_item_t fifo_mem [FIFO_DEPTH];

  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  deq;

  assign rd_valid_o = (count_q != '0);
  assign rd_item_o  = fifo_mem[rd_ptr_q];
  assign deq        = rd_valid_o && !rd_stall_i;

  always_ff @(posedge clk_i) begin
    if (wr_valid_i) begin
      fifo_mem[wr_ptr_q] <= wr_item_i;
    end
  end

  always_comb begin
    count_d = count_q + FIFO_CNT_W'(wr_valid_i) - FIFO_CNT_W'(deq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_valid_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (deq) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

endmodule

/* rtl/outlier_gated_gaussian_smoother.sv */
// top level: configuration registers, raster counters, credit control
// depends on ogs_pkg, ogs_line_window, ogs_gauss, ogs_out_fifo
//
//  channel | handshake                    | payload
//  --------+------------------------------+-------------------------------------------
//  in      | in_valid_i / in_stall_o      | pixel_in_i, padding_i
//  out     | out_valid_o / out_stall_i    | pixel_out_o, was_smoothed_o, frame_last_o
//  cfg     | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
// one item per clock while in_stall_o is low: each item costs one read and one write
// of the line store memory (four rows per word), issued on consecutive cycles.
// a result passes the line store read, the window and the gaussian pipeline into the queue.
// in_stall_o rises once 16 results are owed and not yet taken by the output.
// reset clears counters, window and queue; the line store has no clearing pass.

module outlier_gated_gaussian_smoother
  import ogs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIX_W-1:0]      pixel_in_i,
  input  logic                  padding_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIX_W-1:0]      pixel_out_o,
  output logic                  was_smoothed_o,
  output logic                  frame_last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // configuration registers
  logic [PIX_W-1:0] upper_limit_q, lower_limit_q;
  logic [LW_W-1:0]  line_width_q;
  logic [ROW_W-1:0] line_count_q;

  // raster position counters
  logic [COL_W-1:0]    in_column_q, in_column_d;
  logic [IN_ROW_W-1:0] in_row_q, in_row_d;
  logic [COL_W-1:0]    out_column_q, out_column_d;
  logic [ROW_W-1:0]    out_row_q, out_row_d;

  // results owed: accepted and not yet delivered
  logic [FIFO_CNT_W-1:0] owed_q, owed_d;

  logic [LW_W-1:0]  eff_w;
  logic [ROW_W-1:0] eff_h;
  logic             accept, flushing, take, emit;
  logic             in_col_wrap, out_col_end, out_row_end, interior, last;
  logic [LW_W-1:0]  in_col_next, out_col_next;
  logic [ROW_W:0]   out_row_next;
  logic             deq;

  line_item_t line_item;
  win_ctl_t   win_ctl;
  window_t    window;
  logic       res_valid;
  out_item_t  res_item, out_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_limit_q <= '1;
      lower_limit_q <= '0;
      line_width_q  <= LW_W'(2048);
      line_count_q  <= ROW_W'(2048);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_UPPER_LIMIT: upper_limit_q <= cfg_data_i[PIX_W-1:0];
        REG_LOWER_LIMIT: lower_limit_q <= cfg_data_i[PIX_W-1:0];
        REG_LINE_WIDTH:  line_width_q  <= cfg_data_i[LW_W-1:0];
        REG_LINE_COUNT:  line_count_q  <= cfg_data_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // geometry in use: width held in 5..MAX_LINE, height at least 5
  always_comb begin
    if (line_width_q < LW_W'(MIN_DIM)) begin
      eff_w = LW_W'(MIN_DIM);
    end else if (line_width_q > LW_W'(MAX_LINE)) begin
      eff_w = LW_W'(MAX_LINE);
    end else begin
      eff_w = line_width_q;
    end
    eff_h = (line_count_q < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : line_count_q;
  end

  assign in_stall_o = (owed_q >= FIFO_CNT_W'(FIFO_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  // past the last row every item flushes; padding inside the frame is dropped
  assign flushing = (in_row_q >= IN_ROW_W'(eff_h));
  assign take     = accept && (flushing || !padding_i);

  // no result until the input reaches row 2, column 2
  assign emit = (in_row_q > IN_ROW_W'(EDGE)) ||
                ((in_row_q == IN_ROW_W'(EDGE)) && (in_column_q >= COL_W'(EDGE)));

  always_comb begin
    in_col_next  = {1'b0, in_column_q} + LW_W'(1);
    in_col_wrap  = (in_col_next >= eff_w);
    out_col_next = {1'b0, out_column_q} + LW_W'(1);
    out_col_end  = (out_col_next >= eff_w);
    out_row_next = {1'b0, out_row_q} + (ROW_W+1)'(1);
    out_row_end  = (out_row_next >= {1'b0, eff_h});
    last         = out_col_end && out_row_end;

    // centre at least two pixels from every frame edge
    interior = (out_row_q >= ROW_W'(EDGE)) &&
               (({1'b0, out_row_q} + (ROW_W+1)'(EDGE)) < {1'b0, eff_h}) &&
               (out_column_q >= COL_W'(EDGE)) &&
               (({1'b0, out_column_q} + LW_W'(EDGE)) < eff_w);

    in_column_d  = in_column_q;
    in_row_d     = in_row_q;
    out_column_d = out_column_q;
    out_row_d    = out_row_q;

    if (take) begin
      if (in_col_wrap) begin
        in_column_d = '0;
        in_row_d    = in_row_q + IN_ROW_W'(1);
      end else begin
        in_column_d = in_col_next[COL_W-1:0];
      end
      if (emit) begin
        if (last) begin
          // frame end clears every position counter
          in_column_d  = '0;
          in_row_d     = '0;
          out_column_d = '0;
          out_row_d    = '0;
        end else if (out_col_end) begin
          out_column_d = '0;
          out_row_d    = out_row_next[ROW_W-1:0];
        end else begin
          out_column_d = out_col_next[COL_W-1:0];
        end
      end
    end
  end

  assign deq    = out_valid_o && !out_stall_i;
  assign owed_d = owed_q + FIFO_CNT_W'(take && emit) - FIFO_CNT_W'(deq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_column_q  <= '0;
      in_row_q     <= '0;
      out_column_q <= '0;
      out_row_q    <= '0;
      owed_q       <= '0;
    end else begin
      in_column_q  <= in_column_d;
      in_row_q     <= in_row_d;
      out_column_q <= out_column_d;
      out_row_q    <= out_row_d;
      owed_q       <= owed_d;
    end
  end

  // flush items enter as zero
  always_comb begin
    line_item.valid    = take;
    line_item.emit     = emit;
    line_item.pix      = flushing ? '0 : pixel_in_i;
    line_item.col      = in_column_q;
    line_item.interior = interior;
    line_item.last     = last;
  end

  ogs_line_window u_line_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (line_item),
    .ctl_o  (win_ctl),
    .win_o  (window)
  );

  ogs_gauss u_gauss (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (win_ctl),
    .win_i       (window),
    .upper_i     (upper_limit_q),
    .lower_i     (lower_limit_q),
    .res_valid_o (res_valid),
    .res_o       (res_item)
  );

  ogs_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (res_valid),
    .wr_item_i  (res_item),
    .rd_valid_o (out_valid_o),
    .rd_stall_i (out_stall_i),
    .rd_item_o  (out_item)
  );

  assign pixel_out_o    = out_item.pixel;
  assign was_smoothed_o = out_item.smoothed;
  assign frame_last_o   = out_item.last;

endmodule
